### src/ordered_array_store_unit_defines.svh
// assertion macros shared by the ordered array store rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ORDERED_ARRAY_STORE_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_STORE_UNIT_DEFINES_SVH

// expression holds at every clock edge out of reset
`define OAS_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define OAS_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define OAS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### src/oas_pkg.sv
// shared types and codes of the ordered array store
// no dependencies
`default_nettype none

package oas_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 7;
  localparam int AT_W   = 6;
  localparam int ST_W   = 2;
  localparam int FUNC_W = 3;

  localparam logic [FUNC_W-1:0] F_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] F_APPEND = 3'd1;
  localparam logic [FUNC_W-1:0] F_POP    = 3'd2;
  localparam logic [FUNC_W-1:0] F_DELETE = 3'd3;
  localparam logic [FUNC_W-1:0] F_SEARCH = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECT  = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET    = 7'd64;
  localparam logic             REG_CAPACITY = 1'b0;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_SWAP
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic              key_mode;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  fill;
    logic [WORD_W-1:0] val;
  } cell_cmd_t;

endpackage

`default_nettype wire

### src/oas_cell.sv
// one storage cell of the ordered array store chain
// depends on oas_pkg
`default_nettype none

module oas_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  wire logic                        clk_i,
  input  wire oas_pkg::cell_cmd_t          cmd_i,
  input  wire logic [oas_pkg::WORD_W-1:0]  left_i,
  input  wire logic [oas_pkg::WORD_W-1:0]  right_i,
  output logic      [oas_pkg::WORD_W-1:0]  word_o,
  output logic                             match_o
);
  import oas_pkg::*;

  localparam int CW = ((IW > POS_W) ? IW : POS_W) + 1;

  logic [WORD_W-1:0] word_q, word_d;
  logic [CW-1:0]     my_idx, pos_x, pos_nx, fill_x;
  logic              is_at, is_above, is_next;

  assign my_idx   = CW'(IDX);
  assign pos_x    = CW'(cmd_i.pos);
  assign pos_nx   = pos_x + CW'(1);
  assign fill_x   = CW'(cmd_i.fill);
  assign is_at    = (my_idx == pos_x);
  assign is_above = (my_idx > pos_x);
  assign is_next  = (my_idx == pos_nx);

  always_comb begin
    word_d = word_q;
    case (cmd_i.op)
      OP_INS: begin
        if (is_above) begin
          word_d = left_i;
        end else if (is_at) begin
          word_d = cmd_i.val;
        end
      end
      OP_DEL: begin
        if (is_above || is_at) begin
          word_d = right_i;
        end
      end
      OP_SWAP: begin
        if (is_at) begin
          word_d = right_i;
        end else if (is_next) begin
          word_d = left_i;
        end
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  // key compare for search, position select for delete, both limited to live entries
  assign match_o = (cmd_i.key_mode ? (word_q == cmd_i.val) : is_at) && (my_idx < fill_x);

endmodule

`default_nettype wire

### src/oas_first.sv
// registered reduction tree that finds the lowest flagged cell, one level per cycle
// depends on oas_pkg and ordered_array_store_unit_defines.svh
`default_nettype none

`include "ordered_array_store_unit_defines.svh"

module oas_first #(
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   load_i,
  input  wire logic [DEPTH-1:0]                       match_i,
  input  wire logic [DEPTH-1:0][oas_pkg::WORD_W-1:0]  word_i,
  output logic                                        done_o,
  output logic                                        hit_o,
  output logic      [$clog2(DEPTH)-1:0]               idx_o,
  output logic      [oas_pkg::WORD_W-1:0]             word_o
);
  import oas_pkg::*;

  localparam int LG = $clog2(DEPTH);
  localparam int N  = 1 << LG;
  localparam int CW = $clog2(LG + 1);

  logic [N-1:0]             hit_q, hit_d, src_hit;
  logic [N-1:0][LG-1:0]     idx_q, idx_d;
  logic [N-1:0][WORD_W-1:0] wd_q, wd_d, src_wd;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     step;

  for (genvar k = 0; k < N; k++) begin : g_src
    if (k < DEPTH) begin : g_live
      assign src_hit[k] = match_i[k];
      assign src_wd[k]  = word_i[k];
    end else begin : g_pad
      assign src_hit[k] = 1'b0;
      assign src_wd[k]  = '0;
    end
  end

  assign step = (cnt_q != CW'(LG));

  always_comb begin
    hit_d = hit_q;
    idx_d = idx_q;
    wd_d  = wd_q;
    cnt_d = cnt_q;
    if (load_i) begin
      hit_d = src_hit;
      wd_d  = src_wd;
      for (int k = 0; k < N; k++) begin
        idx_d[k] = LG'(k);
      end
      cnt_d = '0;
    end else if (step) begin
      // pairwise pick, the lower index of each pair wins
      for (int k = 0; k < N / 2; k++) begin
        hit_d[k] = hit_q[2*k] | hit_q[2*k+1];
        idx_d[k] = hit_q[2*k] ? idx_q[2*k] : idx_q[2*k+1];
        wd_d[k]  = hit_q[2*k] ? wd_q[2*k]  : wd_q[2*k+1];
      end
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CW'(LG);
      hit_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    wd_q  <= wd_d;
  end

  assign done_o = !step;
  assign hit_o  = hit_q[0];
  assign idx_o  = idx_q[0];
  assign word_o = wd_q[0];

  `OAS_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(LG), "reduction counter out of range")
  `OAS_ASSERT_NEXT(a_done_holds, done_o && !load_i, done_o, "result dropped before reload")

endmodule

`default_nettype wire

### src/ordered_array_store_unit.sv
// top level of the ordered array store: control, result register, config port
// depends on oas_pkg, oas_cell, oas_first and ordered_array_store_unit_defines.svh
`default_nettype none

`include "ordered_array_store_unit_defines.svh"

// ordered array store: dense list of signed 32-bit words kept in a chain of cells
// input channel (in_valid_i/in_ready_o) carries func, position and value; each
// transaction yields exactly one result transaction on out_valid_o/out_ready_i
// carrying status, data, found_at and count.
// insert, append, pop and every rejected request finish in the accept cycle:
// the result register is loaded at that edge, so a new request can follow in
// the next cycle when the receiver is ready to take that result.
// delete and search flag cells in the accept cycle, then a registered tree
// reduces the flags one level per cycle, and the shift or swap is applied
// together with the result load once the tree is done and the result
// register is free; no new request is taken in the meantime.
// the capacity register is to be written over the apb port while the unit is idle
// (the unit does not enforce it); the limit is the smaller of capacity and DEPTH.
// reset empties the list (count zero) and sets capacity to 64; cell contents
// are not cleared and need no clearing pass since only live entries are read.
// a stalled receiver holds the result register; the unit then drops in_ready_o
// and a finished search or delete waits with its tree result held.
module ordered_array_store_unit #(
  parameter int DEPTH = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // apb configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [oas_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [oas_pkg::POS_W-1:0]    position_i,
  input  wire logic signed [oas_pkg::WORD_W-1:0] value_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [oas_pkg::ST_W-1:0]     status_o,
  output logic signed [oas_pkg::WORD_W-1:0] data_o,
  output logic      [oas_pkg::AT_W-1:0]     found_at_o,
  output logic      [oas_pkg::CNT_W-1:0]    count_o
);
  import oas_pkg::*;

  localparam int IW      = $clog2(DEPTH);
  localparam int LIM_MAX = (DEPTH > 127) ? 127 : DEPTH;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SCAN = 1'b1;

  // control state
  logic [0:0]       state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cap_q;
  logic             del_q, del_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] lim;

  // result register
  logic              out_valid_q;
  logic [ST_W-1:0]   st_q, st_d;
  logic [WORD_W-1:0] data_q, data_d;
  logic [AT_W-1:0]   at_q, at_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_free, out_load, in_acc;

  // chain and tree
  cell_cmd_t                cmd;
  logic [DEPTH-1:0][WORD_W-1:0] cell_word;
  logic [DEPTH-1:0]         cell_match;
  logic                     tr_load, tr_done, tr_hit;
  logic [IW-1:0]            tr_idx;
  logic [WORD_W-1:0]        tr_word;
  logic [POS_W-1:0]         swap_pos;
  logic                     cfg_wr;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      cap_q <= pwdata[CNT_W-1:0];
    end
  end

  assign lim = (cap_q > CNT_W'(LIM_MAX)) ? CNT_W'(LIM_MAX) : cap_q;

  // handshakes
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign swap_pos   = POS_W'(tr_idx) - POS_W'(1);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    del_d        = del_q;
    pos_d        = pos_q;
    out_load     = 1'b0;
    tr_load      = 1'b0;
    st_d         = ST_REJECT;
    data_d       = '0;
    at_d         = '0;
    cmd.op       = OP_HOLD;
    cmd.key_mode = (func_i == F_SEARCH);
    cmd.pos      = position_i;
    cmd.fill     = fill_q;
    cmd.val      = $unsigned(value_i);
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          del_d    = (func_i == F_DELETE);
          pos_d    = position_i;
          case (func_i)
            F_INSERT: begin
              if ((position_i <= fill_q) && (fill_q < lim)) begin
                cmd.op = OP_INS;
                fill_d = fill_q + CNT_W'(1);
                st_d   = ST_DONE;
              end
            end
            F_APPEND: begin
              // append is an insert at the end of the list
              if (fill_q < lim) begin
                cmd.op  = OP_INS;
                cmd.pos = fill_q;
                fill_d  = fill_q + CNT_W'(1);
                st_d    = ST_DONE;
              end
            end
            F_POP: begin
              if (fill_q != '0) begin
                fill_d = fill_q - CNT_W'(1);
                st_d   = ST_DONE;
              end
            end
            F_DELETE: begin
              if (position_i < fill_q) begin
                out_load = 1'b0;
                tr_load  = 1'b1;
                state_d  = S_SCAN;
              end
            end
            F_SEARCH: begin
              out_load = 1'b0;
              tr_load  = 1'b1;
              state_d  = S_SCAN;
            end
            default: begin
              st_d = ST_REJECT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tr_done && out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (del_q) begin
            // removed word comes out of the tree, cells above close the gap
            cmd.op  = OP_DEL;
            cmd.pos = pos_q;
            data_d  = tr_word;
            fill_d  = fill_q - CNT_W'(1);
            st_d    = ST_DONE;
          end else if (tr_hit) begin
            st_d = ST_DONE;
            if (tr_idx != '0) begin
              // transpose the match with its front neighbor
              cmd.op  = OP_SWAP;
              cmd.pos = swap_pos;
              at_d    = AT_W'(swap_pos);
            end
          end else begin
            st_d = ST_MISSING;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      del_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      del_q   <= del_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (out_load) begin
      st_q   <= st_d;
      data_q <= data_d;
      at_q   <= at_d;
      cnt_q  <= fill_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = st_q;
  assign data_o      = $signed(data_q);
  assign found_at_o  = at_q;
  assign count_o     = cnt_q;

  // chain of cells, each hands its word to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    oas_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[i]),
      .match_o (cell_match[i])
    );
  end

  oas_first #(
    .DEPTH (DEPTH)
  ) u_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (tr_load),
    .match_i (cell_match),
    .word_i  (cell_word),
    .done_o  (tr_done),
    .hit_o   (tr_hit),
    .idx_o   (tr_idx),
    .word_o  (tr_word)
  );

  `OAS_ASSERT_ALWAYS(a_fill_bound, fill_q <= CNT_W'(LIM_MAX), "fill count beyond storage")
  `OAS_ASSERT_IMPLIES(a_scan_done, (state_q == S_SCAN) && out_load, tr_done, "result before tree done")
  `OAS_ASSERT_NEXT(a_fill_step, 1'b1, (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + CNT_W'(1)) || (fill_q == $past(fill_q) - CNT_W'(1)), "fill count jumped")

endmodule

`default_nettype wire

### test/tb_ordered_array_store_unit.sv
// self-checking testbench of ordered_array_store_unit: directed and random list operations
// over several capacity settings, each result checked against a behavioral list predictor
// depends on oas_pkg and the rtl of ordered_array_store_unit
`default_nettype none

module tb_ordered_array_store_unit;
  import oas_pkg::*;

  localparam int STORE_DEPTH    = 64;
  // long enough for a delete or search to finish, with a margin
  localparam int SETTLE_CYCLES  = $clog2(STORE_DEPTH) + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int POS_MAX        = (1 << POS_W) - 1;
  localparam int FUNC_MAX       = (1 << FUNC_W) - 1;
  // register i sits at byte address 4*i
  localparam logic [2:0] CAPACITY_ADDR = 3'(4 * int'(REG_CAPACITY));

  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hffff_ffff;

  // operation mixes of the random part
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN   = 2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [WORD_W-1:0] data;
    logic [AT_W-1:0]          found_at;
    logic [CNT_W-1:0]         count;
  } outcome_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // apb side
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // request and result channels
  request_t                 req_drv   = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ST_W-1:0]          status;
  logic signed [WORD_W-1:0] data;
  logic [AT_W-1:0]          found_at;
  logic [CNT_W-1:0]         count;

  // predictor state: list contents, fill level and capacity register
  logic signed [WORD_W-1:0] store [STORE_DEPTH];
  int live         = 0;
  int capacity_now = int'(CAP_RESET);
  int peak_live    = 0;

  // requests waiting for the driver, outcomes waiting for the result channel
  request_t pending_reqs[$];
  outcome_t awaited_results[$];

  int mismatches = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_done     = 0;
  int n_reject   = 0;
  int n_missing  = 0;
  int n_settings = 0;

  int send_gap    = 0;
  int recv_stall  = 0;
  bit send_quiet  = 1'b0;
  bit recv_quiet  = 1'b0;
  int idle_cycles = 0;

  ordered_array_store_unit #(
    .DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .func_i     (req_drv.func),
    .position_i (req_drv.pos),
    .value_i    (req_drv.val),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .data_o     (data),
    .found_at_o (found_at),
    .count_o    (count)
  );

  always #6 clk_i = ~clk_i;

  // gap length: mostly none, some short, a few long; zero in quiet stretches
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // applies one request to the list copy and returns the outcome it must produce
  function automatic outcome_t apply_list_op(input request_t rq);
    outcome_t                 res;
    int                       lim;
    int                       i;
    bit                       hit;
    logic signed [WORD_W-1:0] t;
    res = '0;
    res.status = ST_REJECT;
    // capacity above the store depth saturates
    lim = (capacity_now > STORE_DEPTH) ? STORE_DEPTH : capacity_now;
    case (rq.func)
      F_INSERT: begin
        if (int'(rq.pos) <= live && live < lim) begin
          for (i = live; i > int'(rq.pos); i--) store[i] = store[i-1];
          store[rq.pos] = rq.val;
          live++;
          res.status = ST_DONE;
        end
      end
      F_APPEND: begin
        if (live < lim) begin
          store[live] = rq.val;
          live++;
          res.status = ST_DONE;
        end
      end
      F_POP: begin
        if (live != 0) begin
          live--;
          res.status = ST_DONE;
        end
      end
      F_DELETE: begin
        if (int'(rq.pos) < live) begin
          res.data = store[rq.pos];
          for (i = int'(rq.pos); i + 1 < live; i++) store[i] = store[i+1];
          live--;
          res.status = ST_DONE;
        end
      end
      F_SEARCH: begin
        // first match moves one place toward the front
        res.status = ST_MISSING;
        hit = 1'b0;
        for (i = 0; i < live && !hit; i++) begin
          if (store[i] == rq.val) begin
            hit = 1'b1;
            res.status = ST_DONE;
            if (i > 0) begin
              t          = store[i];
              store[i]   = store[i-1];
              store[i-1] = t;
              res.found_at = AT_W'(i - 1);
            end
          end
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(live);
    if (live > peak_live) peak_live = live;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // request driver: valid stays up with a steady payload until the transaction is taken
  always @(posedge clk_i) begin
    request_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        req_drv  <= nxt;
        in_valid <= 1'b1;
        n_sent++;
        send_gap <= pick_gap(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, with quiet stretches of none
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (recv_stall != 0) begin
      out_ready  <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      out_ready  <= 1'b1;
      recv_stall <= pick_gap(recv_quiet);
    end
  end

  // monitor: predict on every request transaction, check on every result transaction
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) awaited_results.push_back(apply_list_op(req_drv));
      if (out_valid && out_ready) begin
        n_checked++;
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no request outstanding", n_checked));
        end else begin
          want = awaited_results.pop_front();
          case (want.status)
            ST_DONE:    n_done++;
            ST_REJECT:  n_reject++;
            ST_MISSING: n_missing++;
            default: ;
          endcase
          if (status !== want.status)
            flag_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    n_checked, status, want.status));
          if (data !== want.data)
            flag_mismatch($sformatf("result %0d data %h, expected %h",
                                    n_checked, data, want.data));
          if (found_at !== want.found_at)
            flag_mismatch($sformatf("result %0d found_at %0d, expected %0d",
                                    n_checked, found_at, want.found_at));
          if (count !== want.count)
            flag_mismatch($sformatf("result %0d count %0d, expected %0d",
                                    n_checked, count, want.count));
        end
      end
    end
  end

  // watchdog: too many cycles in a row with no transaction on any port
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, awaited_results.size());
        $display("ordered_array_store_unit regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // queue changes happen on the falling edge, away from the clocked processes
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || awaited_results.size() != 0 || in_valid)
      @(negedge clk_i);
  endtask

  task automatic queue_req(input logic [FUNC_W-1:0] f, input int p,
                           input logic [WORD_W-1:0] v);
    request_t rq;
    rq.func = f;
    rq.pos  = POS_W'(p);
    rq.val  = v;
    pending_reqs.push_back(rq);
  endtask

  // capacity write over apb, only once the unit has gone quiet
  task automatic set_capacity(input int cap);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= 32'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    // register takes the value at the access edge
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    capacity_now = cap & POS_MAX;
    n_settings++;
    @(negedge clk_i);
    // read back the register while the address still points at it
    if (prdata !== 32'(capacity_now))
      flag_mismatch($sformatf("capacity reads %0d, expected %0d", prdata, capacity_now));
  endtask

  // word for insert or append: extremes, repeats of live entries, or anything
  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return WORD_MIN;
    if (r < 6) return WORD_MAX;
    if (r < 9) return '0;
    if (r < 12) return WORD_ONES;
    if (r < 37 && live > 0) return store[$urandom_range(0, live - 1)];
    return $urandom;
  endfunction

  // one burst of random requests, shaped around the fill level at its start
  task automatic queue_random_burst(input int mix, input int n);
    int       est, lim, w, k;
    int       t_ins, t_app, t_del, t_pop, t_srch;
    request_t rq;
    wait_drained();
    send_quiet <= ($urandom_range(0, 4) == 0);
    recv_quiet <= ($urandom_range(0, 4) == 0);
    est = live;
    lim = (capacity_now > STORE_DEPTH) ? STORE_DEPTH : capacity_now;
    case (mix)
      MIX_GROW:   begin t_ins = 35; t_app = 65; t_del = 75; t_pop = 80; t_srch = 95; end
      MIX_SHRINK: begin t_ins = 10; t_app = 20; t_del = 55; t_pop = 75; t_srch = 95; end
      default:    begin t_ins = 20; t_app = 35; t_del = 55; t_pop = 65; t_srch = 95; end
    endcase
    for (k = 0; k < n; k++) begin
      w = $urandom_range(0, 99);
      rq.val = pick_word();
      rq.pos = POS_W'($urandom_range(0, POS_MAX));
      if (w < t_ins) begin
        rq.func = F_INSERT;
        if ($urandom_range(0, 99) < 88) rq.pos = POS_W'($urandom_range(0, est));
        if (est < lim) est++;
      end else if (w < t_app) begin
        rq.func = F_APPEND;
        if (est < lim) est++;
      end else if (w < t_del) begin
        rq.func = F_DELETE;
        if (est > 0 && $urandom_range(0, 99) < 88) rq.pos = POS_W'($urandom_range(0, est - 1));
        if (est > 0) est--;
      end else if (w < t_pop) begin
        rq.func = F_POP;
        if (est > 0) est--;
      end else if (w < t_srch) begin
        rq.func = F_SEARCH;
        if (live > 0 && $urandom_range(0, 99) < 75) rq.val = store[$urandom_range(0, live - 1)];
      end else begin
        // undefined operation codes
        rq.func = FUNC_W'($urandom_range(int'(F_SEARCH) + 1, FUNC_MAX));
      end
      pending_reqs.push_back(rq);
    end
  endtask

  task automatic run_phase(input int cap, input int mix, input int n);
    int chunk;
    set_capacity(cap);
    while (n > 0) begin
      chunk = $urandom_range(4, 24);
      if (chunk > n) chunk = n;
      queue_random_burst(mix, chunk);
      n -= chunk;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: pop, delete and insert past the end refused, search finds nothing
    queue_req(F_POP, 0, '0);
    queue_req(F_DELETE, 0, '0);
    queue_req(F_SEARCH, 0, '0);
    queue_req(F_INSERT, 1, 32'd5);
    // build a list from the word extremes, inserting at front, middle and end
    queue_req(F_INSERT, 0, WORD_MIN);
    queue_req(F_APPEND, 0, WORD_MAX);
    queue_req(F_APPEND, 0, WORD_ONES);
    queue_req(F_INSERT, 1, '0);
    queue_req(F_INSERT, 4, 32'h5555_5555);
    // positions beyond the end and at the largest encodable value
    queue_req(F_INSERT, POS_MAX, 32'd1);
    queue_req(F_DELETE, POS_MAX, '0);
    queue_req(F_DELETE, 5, '0);
    // match at the front, match further in (swaps), no match
    queue_req(F_SEARCH, 0, WORD_MIN);
    queue_req(F_SEARCH, 0, WORD_ONES);
    queue_req(F_SEARCH, 0, 32'h1234_5678);
    // undefined operation codes
    for (int f = int'(F_SEARCH) + 1; f <= FUNC_MAX; f++)
      queue_req(FUNC_W'(f), POS_MAX, WORD_ONES);
    // delete at front and at the last entry, pop, append
    queue_req(F_DELETE, 0, '0);
    queue_req(F_DELETE, 3, '0);
    queue_req(F_POP, 0, '0);
    queue_req(F_APPEND, 0, 32'haaaa_aaaa);

    // capacity zero refuses every insert and append, pop still works
    set_capacity(0);
    queue_req(F_APPEND, 0, 32'd7);
    queue_req(F_INSERT, 0, 32'd7);
    queue_req(F_POP, 0, '0);

    // random part over a spread of capacities, fill and drain phases included
    run_phase(64, MIX_GROW, 140);
    run_phase(64, MIX_SHRINK, 50);
    run_phase(1, MIX_EVEN, 40);
    run_phase(2, MIX_GROW, 40);
    run_phase(5, MIX_EVEN, 50);
    run_phase(127, MIX_GROW, 80);
    run_phase(17, MIX_SHRINK, 50);
    run_phase(40, MIX_EVEN, 50);
    run_phase(64, MIX_EVEN, 50);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("covered %0d requests and %0d checked results over %0d capacity settings",
             n_sent, n_checked, n_settings);
    $display("outcomes: %0d done, %0d refused, %0d not found; list reached %0d entries",
             n_done, n_reject, n_missing, peak_live);
    if (mismatches == 0) begin
      $display("ordered_array_store_unit regression: pass");
    end else begin
      $display("ordered_array_store_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
